### rtl/core/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit page allocator
// Page geometry, field widths, operation and status codes, and the
// command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // Page table geometry
  localparam int MAX_PAGES  = 512;
  localparam int PAGE_AW    = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_AW + 1;
  localparam int PAGE_SHIFT = 11;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  // Field widths
  localparam int SIZE_W     = 21;
  localparam int ADDR_W     = 24;
  localparam int KIB_W      = 11;
  localparam int KIB_MAX    = (1 << KIB_W) - 1;
  localparam int NEED_W     = SIZE_W - PAGE_SHIFT + 1;
  localparam int USABLE_W   = 10;
  localparam int STATUS_W   = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // Register reset values: base is 0x3400 paragraphs
  localparam logic [USABLE_W-1:0] USABLE_RESET = USABLE_W'(440);
  localparam logic [ADDR_W-1:0]   BASE_RESET   = ADDR_W'(32'h3400 * 16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USABLE_PAGES = 1'b0,
    CFG_BASE_ADDRESS = 1'b1
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_MEM    = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_ZERO_SIZE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CS_INIT,
    CS_IDLE,
    CS_DECODE,
    CS_COUNT,
    CS_SEARCH,
    CS_MARK,
    CS_RELEASE,
    CS_REPLY
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_HOLD,
    PH_INIT,
    PH_COUNT,
    PH_SEARCH,
    PH_MARK,
    PH_RELEASE
  } dp_phase_t;

  // Controller to datapath
  typedef struct packed {
    dp_phase_t phase;
    logic      take;
    logic      ld_scan;
    logic      ld_count;
    logic      ld_mark;
    logic      ld_rel;
    logic      finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_done;
    logic scan_end;
    logic hit;
    logic mark_last;
    logic dirty;
    logic is_alloc;
    logic is_free;
    logic zero_size;
    logic out_busy;
  } dp_sts_t;

endpackage

### rtl/core/ffpa_req_if.sv
// ----------------------------------------------------------------------------
// ffpa_req_if: request channel of the page allocator
// Valid/ready channel carrying one request word: kind, size and address.
// ----------------------------------------------------------------------------
interface ffpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [ffpa_pkg::KIND_W-1:0]   kind;
  logic [ffpa_pkg::SIZE_W-1:0]   size_bytes;
  logic [ffpa_pkg::ADDR_W-1:0]   release_address;

  modport source (output valid, output kind, output size_bytes,
                  output release_address, input ready);
  modport sink   (input valid, input kind, input size_bytes,
                  input release_address, output ready);
endinterface

### rtl/core/ffpa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffpa_rsp_if: response channel of the page allocator
// Valid/ready channel carrying one response word: status, address, free KiB.
// ----------------------------------------------------------------------------
interface ffpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffpa_pkg::STATUS_W-1:0] status;
  logic [ffpa_pkg::ADDR_W-1:0]   block_address;
  logic [ffpa_pkg::KIB_W-1:0]    free_kib;

  modport source (output valid, output status, output block_address,
                  output free_kib, input ready);
  modport sink   (input valid, input status, input block_address,
                  input free_kib, output ready);
endinterface

### rtl/core/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ffpa_datapath.sv
// ----------------------------------------------------------------------------
// ffpa_datapath: page table, scan pipeline and response register
// Holds the used-page and run-length memories, the configuration
// registers, the in-range used-page count and the response word.
// ----------------------------------------------------------------------------
module ffpa_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ffpa_pkg::dp_cmd_t                 cmd,
  output ffpa_pkg::dp_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [ffpa_pkg::KIND_W-1:0]       req_kind,
  input  logic [ffpa_pkg::SIZE_W-1:0]       req_size_bytes,
  input  logic [ffpa_pkg::ADDR_W-1:0]       req_release_address,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic [ffpa_pkg::STATUS_W-1:0]     rsp_status,
  output logic [ffpa_pkg::ADDR_W-1:0]       rsp_block_address,
  output logic [ffpa_pkg::KIB_W-1:0]        rsp_free_kib
);

  localparam int AW = ffpa_pkg::PAGE_AW;
  localparam int CW = ffpa_pkg::CNT_W;

  // Configuration and control state
  logic [ffpa_pkg::USABLE_W-1:0] usable_pages;
  logic [ffpa_pkg::ADDR_W-1:0]   base_address;
  logic                          dirty;
  logic [CW-1:0]                 idx;
  logic                          pv;
  logic                          hit;
  logic [CW-1:0]                 used_cnt;

  // Item and scan payload
  logic [ffpa_pkg::KIND_W-1:0]   kind_q;
  logic                          zero_q;
  logic [ffpa_pkg::NEED_W-1:0]   need;
  logic [ffpa_pkg::ADDR_W-1:0]   rel_addr;
  logic [AW-1:0]                 pidx;
  logic [CW-1:0]                 run;
  logic [AW-1:0]                 first;
  logic [CW-1:0]                 stop;
  logic [AW-1:0]                 wptr;
  logic [CW-1:0]                 mk;

  // Combinational helpers
  logic [CW-1:0]                 lim;
  logic [CW-1:0]                 bound;
  logic                          scanning;
  logic                          issue;
  logic                          eval_search;
  logic                          used_q;
  logic [CW-1:0]                 rend_q;
  logic [CW-1:0]                 run_inc;
  logic                          run_fit;
  logic [ffpa_pkg::ADDR_W-1:0]   paddr;
  logic [CW:0]                   end_sum;
  logic [CW-1:0]                 end_clip;
  logic [ffpa_pkg::SIZE_W:0]     size_round;
  logic [CW-1:0]                 free_pg;
  logic [ffpa_pkg::KIB_W-1:0]    kib;
  logic                          is_alloc;
  logic                          is_free;
  ffpa_pkg::status_t             status_d;
  logic                          used_we;
  logic [AW-1:0]                 used_waddr;
  logic                          used_wdata;

  // Clamp usable page count to the table size
  assign lim = (int'(usable_pages) > ffpa_pkg::MAX_PAGES) ?
               CW'(ffpa_pkg::MAX_PAGES) : CW'(usable_pages);

  // Scan bound and read issue
  assign bound    = (cmd.phase == ffpa_pkg::PH_RELEASE) ? stop : lim;
  assign scanning = (cmd.phase == ffpa_pkg::PH_COUNT) ||
                    (cmd.phase == ffpa_pkg::PH_SEARCH) ||
                    (cmd.phase == ffpa_pkg::PH_RELEASE);
  assign issue    = scanning && (idx < bound) &&
                    !((cmd.phase == ffpa_pkg::PH_SEARCH) && hit);
  assign eval_search = (cmd.phase == ffpa_pkg::PH_SEARCH) && pv && !hit;

  assign is_alloc = (kind_q == ffpa_pkg::KIND_ALLOC);
  assign is_free  = (kind_q == ffpa_pkg::KIND_FREE);

  // Run tracking and page address of the word in flight
  assign run_inc  = run + CW'(1);
  assign run_fit  = (int'(run_inc) == int'(need));
  assign paddr    = base_address + ffpa_pkg::ADDR_W'({pidx, {ffpa_pkg::PAGE_SHIFT{1'b0}}});
  assign end_sum  = (CW+1)'(pidx) + (CW+1)'(rend_q);
  assign end_clip = (int'(end_sum) > ffpa_pkg::MAX_PAGES) ?
                    CW'(ffpa_pkg::MAX_PAGES) : CW'(end_sum);

  // Round the request up to whole pages
  assign size_round = (ffpa_pkg::SIZE_W+1)'(req_size_bytes) +
                      (ffpa_pkg::SIZE_W+1)'(ffpa_pkg::PAGE_BYTES - 1);

  // Free memory in KiB, two per free usable page
  assign free_pg = lim - used_cnt;
  assign kib     = (int'({free_pg, 1'b0}) > ffpa_pkg::KIB_MAX) ?
                   ffpa_pkg::KIB_W'(ffpa_pkg::KIB_MAX) : ffpa_pkg::KIB_W'({free_pg, 1'b0});

  // Result code of the finished item
  always_comb begin
    status_d = ffpa_pkg::STAT_OK;
    if (is_alloc) begin
      if (zero_q) begin
        status_d = ffpa_pkg::STAT_ZERO_SIZE;
      end else if (!hit) begin
        status_d = ffpa_pkg::STAT_NO_MEM;
      end
    end else if (is_free) begin
      if (!hit) begin
        status_d = ffpa_pkg::STAT_NOT_FOUND;
      end
    end
  end

  // Used-page memory write port
  always_comb begin
    used_we    = 1'b0;
    used_waddr = idx[AW-1:0];
    used_wdata = 1'b0;
    case (cmd.phase)
      ffpa_pkg::PH_INIT: begin
        used_we = 1'b1;
      end
      ffpa_pkg::PH_MARK: begin
        used_we    = 1'b1;
        used_waddr = wptr;
        used_wdata = 1'b1;
      end
      ffpa_pkg::PH_RELEASE: begin
        used_we    = pv;
        used_waddr = pidx;
      end
      default: begin
        used_we = 1'b0;
      end
    endcase
  end

  ffpa_ram #(.WIDTH(1), .DEPTH(ffpa_pkg::MAX_PAGES)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (used_q)
  );

  ffpa_ram #(.WIDTH(CW), .DEPTH(ffpa_pkg::MAX_PAGES)) u_rend_ram (
    .clk   (clk),
    .we    (cmd.phase == ffpa_pkg::PH_MARK),
    .waddr (wptr),
    .wdata (mk),
    .raddr (idx[AW-1:0]),
    .rdata (rend_q)
  );

  // Control state: config, scan counter, hit, used count, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_pages <= ffpa_pkg::USABLE_RESET;
      base_address <= ffpa_pkg::BASE_RESET;
      dirty        <= 1'b0;
      idx          <= '0;
      pv           <= 1'b0;
      hit          <= 1'b0;
      used_cnt     <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      // Advance the scan or the clearing sweep; no read is issued on a load
      if (cmd.phase == ffpa_pkg::PH_INIT) begin
        idx <= idx + CW'(1);
      end else if (issue) begin
        idx <= idx + CW'(1);
      end
      pv <= issue;

      // Evaluate the word read last cycle
      if (eval_search) begin
        if (is_alloc) begin
          if (!used_q && run_fit) begin
            hit <= 1'b1;
          end
        end else if (used_q && (paddr == rel_addr)) begin
          hit <= 1'b1;
        end
      end
      if ((cmd.phase == ffpa_pkg::PH_COUNT) && pv && used_q) begin
        used_cnt <= used_cnt + CW'(1);
      end
      if ((cmd.phase == ffpa_pkg::PH_RELEASE) && pv && used_q &&
          (CW'(pidx) < lim)) begin
        used_cnt <= used_cnt - CW'(1);
      end
      if ((cmd.phase == ffpa_pkg::PH_COUNT) && !pv && (idx >= lim)) begin
        dirty <= 1'b0;
      end

      // Loads for the next phase
      if (cmd.take) begin
        hit <= 1'b0;
      end
      if (cmd.ld_scan || cmd.ld_count) begin
        idx <= '0;
      end
      if (cmd.ld_count) begin
        used_cnt <= '0;
      end
      if (cmd.ld_mark) begin
        used_cnt <= used_cnt + CW'(need);
      end
      if (cmd.ld_rel) begin
        idx <= CW'(first);
      end

      // Response word hand-off
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // Register writes
      if (cfg_we) begin
        case (ffpa_pkg::cfg_reg_t'(cfg_index))
          ffpa_pkg::CFG_USABLE_PAGES: begin
            usable_pages <= cfg_data[ffpa_pkg::USABLE_W-1:0];
            dirty        <= 1'b1;
          end
          ffpa_pkg::CFG_BASE_ADDRESS: begin
            base_address <= cfg_data[ffpa_pkg::ADDR_W-1:0];
          end
          default: begin
            dirty <= dirty;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      pidx <= idx[AW-1:0];
    end
    if (cmd.ld_scan) begin
      run <= '0;
    end else if (eval_search && is_alloc) begin
      if (used_q) begin
        run <= '0;
      end else begin
        run <= run_inc;
        if (run_fit) begin
          first <= AW'(int'(pidx) + 1 - int'(need));
        end
      end
    end else if (eval_search && used_q && (paddr == rel_addr)) begin
      first <= pidx;
      stop  <= end_clip;
    end
    if (cmd.ld_mark) begin
      wptr <= first;
      mk   <= CW'(need);
    end else if (cmd.phase == ffpa_pkg::PH_MARK) begin
      wptr <= wptr + AW'(1);
      mk   <= mk - CW'(1);
    end
    if (cmd.take) begin
      kind_q   <= req_kind;
      zero_q   <= (req_size_bytes == '0);
      need     <= ffpa_pkg::NEED_W'(size_round >> ffpa_pkg::PAGE_SHIFT);
      rel_addr <= req_release_address;
    end
    if (cmd.finish) begin
      rsp_status        <= status_d;
      rsp_block_address <= (is_alloc && !zero_q && hit) ?
        base_address + ffpa_pkg::ADDR_W'({first, {ffpa_pkg::PAGE_SHIFT{1'b0}}}) : '0;
      rsp_free_kib      <= kib;
    end
  end

  // Status to the controller
  always_comb begin
    sts.init_done = (idx == CW'(ffpa_pkg::MAX_PAGES - 1));
    sts.scan_end  = !pv && (idx >= bound);
    sts.hit       = hit;
    sts.mark_last = (mk == CW'(1));
    sts.dirty     = dirty;
    sts.is_alloc  = is_alloc;
    sts.is_free   = is_free;
    sts.zero_size = zero_q;
    sts.out_busy  = rsp_valid;
  end

  // Used count never exceeds the usable range once settled
  a_used_in_range: assert property (@(posedge clk) disable iff (rst)
    !dirty |-> (used_cnt <= lim))
    else $error("used page count above usable range");

  // Marking stays inside the usable range
  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.phase == ffpa_pkg::PH_MARK) |-> (CW'(wptr) < lim))
    else $error("mark outside usable pages");

  // A release always covers at least the matched page
  a_release_span: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_rel |=> (idx < stop))
    else $error("empty release span");

endmodule

### rtl/core/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl: sequencer of the page allocator
// Walks each request word through recount, search, mark or release and
// reply, and runs the table clearing sweep after reset.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffpa_pkg::dp_sts_t sts,
  output ffpa_pkg::dp_cmd_t cmd
);

  ffpa_pkg::ctrl_state_t state;
  ffpa_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffpa_pkg::CS_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.phase    = ffpa_pkg::PH_HOLD;
    cmd.take     = 1'b0;
    cmd.ld_scan  = 1'b0;
    cmd.ld_count = 1'b0;
    cmd.ld_mark  = 1'b0;
    cmd.ld_rel   = 1'b0;
    cmd.finish   = 1'b0;
    case (state)
      ffpa_pkg::CS_INIT: begin
        cmd.phase = ffpa_pkg::PH_INIT;
        if (sts.init_done) begin
          state_next = ffpa_pkg::CS_IDLE;
        end
      end
      ffpa_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ffpa_pkg::CS_DECODE;
        end
      end
      ffpa_pkg::CS_DECODE: begin
        if (sts.dirty) begin
          cmd.ld_count = 1'b1;
          state_next   = ffpa_pkg::CS_COUNT;
        end else if (sts.is_alloc && sts.zero_size) begin
          state_next = ffpa_pkg::CS_REPLY;
        end else if (sts.is_alloc || sts.is_free) begin
          cmd.ld_scan = 1'b1;
          state_next  = ffpa_pkg::CS_SEARCH;
        end else begin
          state_next = ffpa_pkg::CS_REPLY;
        end
      end
      ffpa_pkg::CS_COUNT: begin
        cmd.phase = ffpa_pkg::PH_COUNT;
        if (sts.scan_end) begin
          state_next = ffpa_pkg::CS_DECODE;
        end
      end
      ffpa_pkg::CS_SEARCH: begin
        cmd.phase = ffpa_pkg::PH_SEARCH;
        if (sts.hit) begin
          if (sts.is_alloc) begin
            cmd.ld_mark = 1'b1;
            state_next  = ffpa_pkg::CS_MARK;
          end else begin
            cmd.ld_rel = 1'b1;
            state_next = ffpa_pkg::CS_RELEASE;
          end
        end else if (sts.scan_end) begin
          state_next = ffpa_pkg::CS_REPLY;
        end
      end
      ffpa_pkg::CS_MARK: begin
        cmd.phase = ffpa_pkg::PH_MARK;
        if (sts.mark_last) begin
          state_next = ffpa_pkg::CS_REPLY;
        end
      end
      ffpa_pkg::CS_RELEASE: begin
        cmd.phase = ffpa_pkg::PH_RELEASE;
        if (sts.scan_end) begin
          state_next = ffpa_pkg::CS_REPLY;
        end
      end
      ffpa_pkg::CS_REPLY: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ffpa_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = ffpa_pkg::CS_INIT;
      end
    endcase
  end

  // A hit ends the search in a table update
  a_hit_updates: assert property (@(posedge clk) disable iff (rst)
    (state == ffpa_pkg::CS_SEARCH) && sts.hit |=>
      (state == ffpa_pkg::CS_MARK) || (state == ffpa_pkg::CS_RELEASE))
    else $error("search hit without table update");

  // Reply loads the response register
  a_reply_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ffpa_pkg::CS_REPLY) && !sts.out_busy |=> sts.out_busy)
    else $error("reply did not present a response word");

endmodule

### rtl/core/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator: first-fit contiguous allocator of 2 KiB pages
//
//   Channel  Dir  Handshake     Word
//   req      in   valid/ready   kind, size_bytes, release_address
//   rsp      out  valid/ready   status, block_address, free_kib
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// One request word at a time. With U the usable page count clamped to 512,
// an allocation or free is decoded, then the page table is scanned at one
// entry a cycle: up to U entries for the search, then need pages are marked
// for an allocation or the released span is cleared to release a block.
// Writing usable_pages adds one recount sweep and a second decode to
// the next item.
// After reset all 512 used-page entries are cleared; no request is
// taken meanwhile. The response register frees the request side, so a new
// word is taken while the last response waits for rsp.ready.
// ----------------------------------------------------------------------------
module first_fit_page_allocator (
  input  logic                            clk,
  input  logic                            rst,
  ffpa_req_if.sink                        req,
  ffpa_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  ffpa_pkg::dp_cmd_t cmd;
  ffpa_pkg::dp_sts_t sts;
  logic              in_ready;

  assign req.ready = in_ready;

  // Sequencer
  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Page table and response register
  ffpa_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .req_kind            (req.kind),
    .req_size_bytes      (req.size_bytes),
    .req_release_address (req.release_address),
    .rsp_ready           (rsp.ready),
    .rsp_valid           (rsp.valid),
    .rsp_status          (rsp.status),
    .rsp_block_address   (rsp.block_address),
    .rsp_free_kib        (rsp.free_kib)
  );

endmodule
